### hw/rtl/lkve_pkg.sv
// Shared types, codes and character constants of the line key/value extractor.
package lkve_pkg;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SEARCH = 2'd1,
      PH_VALUE  = 2'd2
   } phase_type;

   localparam logic [1:0] ST_CHAR = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // True for the two characters that end a line.
   function automatic logic is_line_end(input logic [7:0] ch);
      return (ch == CH_CR) || (ch == CH_LF);
   endfunction

endpackage

### hw/rtl/line_key_value_extractor.sv
// Top level of the line key/value extractor: byte-stream key search and value output.
//
// The block takes a text buffer one byte per request on the req_ channel. A request with
// req_first_byte high starts a new query and samples the key, its length, the wanted
// occurrence index and the declared buffer length; any query in progress is dropped.
// The block searches for the key followed by '='. The first occurrence counts anywhere,
// later ones only right after CR or LF. Once the wanted occurrence is reached, every
// following byte up to CR, LF or NUL comes out on the rsp_ channel with status 0, then a
// single completion result with status 1 and rsp_last high. A NUL while searching, an
// occurrence starting at or past the declared length, or a zero declared length gives
// one not-found result with status 2 and rsp_last high. Most bytes give no result.
//
// A request accepted into the input register is evaluated there, and its result, if any,
// is loaded into the result register and visible from there. One request is
// taken every cycle; the only limit is the single result register. When the receiver
// stalls, the input register still takes one more request, and requests that give no
// result keep flowing past the waiting result. After reset the block is idle, both
// registers are empty and bytes without req_first_byte are ignored.
module line_key_value_extractor #(
   parameter int KEY_MAX       = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [63:0] req_key_text,
   input  logic [3:0]  req_key_length,
   input  logic [9:0]  req_wanted_index,
   input  logic [15:0] req_buffer_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_value_byte,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import lkve_pkg::*;

   // Width of an effective key length (0 up to KEY_MAX).
   localparam int LEN_W = $clog2(KEY_MAX + 1);
   // Stored history of bytes; together with the new byte the window holds KEY_MAX+2.
   localparam int WIN   = KEY_MAX + 1;
   localparam int IDX_W = $clog2(KEY_MAX + 2);
   // Width in which the start position is compared against the declared length.
   localparam int CMP_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;
   localparam logic [POSITION_BITS-1:0] POS_TOP = '1;

   // ---------------------------------------------------------------------------------
   // Request side: the effective key length is worked out before the input register.
   // It is the requested length capped at KEY_MAX and cut at the first NUL of the key.
   // ---------------------------------------------------------------------------------
   logic [8*KEY_MAX+63:0] key_wide;
   logic [8*KEY_MAX-1:0]  key_padded;
   logic [LEN_W-1:0]      key_clamp;
   logic [LEN_W-1:0]      key_len_req;

   always_comb begin
      key_wide   = {{(8*KEY_MAX){1'b0}}, req_key_text};
      key_padded = key_wide[8*KEY_MAX-1:0];
      if ({1'b0, req_key_length} > 5'(KEY_MAX)) begin
         key_clamp = LEN_W'(KEY_MAX);
      end else begin
         key_clamp = LEN_W'(req_key_length);
      end
      key_len_req = key_clamp;
      for (int i = KEY_MAX - 1; i >= 0; i--) begin
         if ((LEN_W'(i) < key_clamp) && (key_padded[8*i +: 8] == CH_NUL)) begin
            key_len_req = LEN_W'(i);
         end
      end
   end

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_first_ff;
   logic [8*KEY_MAX-1:0] in_key_ff;
   logic [LEN_W-1:0]     in_key_len_ff;
   logic [9:0]           in_wanted_ff;
   logic [15:0]          in_limit_ff;

   // Query state.
   phase_type              phase_ff, phase_in;
   logic [7:0]             win_ff [WIN];
   logic [7:0]             win_in [WIN];
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [9:0]             count_ff, count_in;
   logic                   seen_ff, seen_in;
   logic [8*KEY_MAX-1:0]   key_ff, key_in;
   logic [LEN_W-1:0]       key_len_ff, key_len_in;
   logic [9:0]             wanted_ff, wanted_in;
   logic [15:0]            limit_ff, limit_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_last_ff;

   logic       req_fire;
   logic       advance;
   logic       emit;
   logic [7:0] emit_byte;
   logic [1:0] emit_status;
   logic       emit_last;

   // ---------------------------------------------------------------------------------
   // Evaluation of the registered request against the query state. A request with
   // first_byte high sees a freshly started query: cleared history, position and count.
   // ---------------------------------------------------------------------------------
   always_comb begin
      logic [8*KEY_MAX-1:0]     cur_key;
      logic [LEN_W-1:0]         cur_len;
      logic [9:0]               cur_wanted;
      logic [15:0]              cur_limit;
      logic [7:0]               cur_win [WIN];
      logic [POSITION_BITS-1:0] cur_pos;
      logic [9:0]               cur_count;
      logic                     cur_seen;
      phase_type                cur_phase;
      logic [7:0]               win_new [KEY_MAX+2];
      logic [POSITION_BITS-1:0] here;
      logic [POSITION_BITS-1:0] start;
      logic [IDX_W-1:0]         idx;
      logic [7:0]               prev_byte;
      logic                     tag;
      logic                     counted;

      if (in_first_ff) begin
         cur_key    = in_key_ff;
         cur_len    = in_key_len_ff;
         cur_wanted = in_wanted_ff;
         cur_limit  = in_limit_ff;
         for (int j = 0; j < WIN; j++) begin
            cur_win[j] = CH_NUL;
         end
         cur_pos    = '0;
         cur_count  = '0;
         cur_seen   = 1'b0;
         cur_phase  = PH_SEARCH;
      end else begin
         cur_key    = key_ff;
         cur_len    = key_len_ff;
         cur_wanted = wanted_ff;
         cur_limit  = limit_ff;
         for (int j = 0; j < WIN; j++) begin
            cur_win[j] = win_ff[j];
         end
         cur_pos    = pos_ff;
         cur_count  = count_ff;
         cur_seen   = seen_ff;
         cur_phase  = phase_ff;
      end

      // The newest byte enters at index 0; the tag ends there with '='.
      win_new[0] = in_byte_ff;
      for (int j = 1; j < KEY_MAX + 2; j++) begin
         win_new[j] = cur_win[j-1];
      end

      idx = '0;
      tag = (win_new[0] == CH_EQUALS);
      for (int i = 0; i < KEY_MAX; i++) begin
         if (LEN_W'(i) < cur_len) begin
            idx = IDX_W'(cur_len) - IDX_W'(i);
            if (win_new[idx] != cur_key[8*i +: 8]) begin
               tag = 1'b0;
            end
         end
      end

      here      = cur_pos;
      start     = here - POSITION_BITS'(cur_len);
      prev_byte = win_new[IDX_W'(cur_len) + IDX_W'(1)];

      key_in     = cur_key;
      key_len_in = cur_len;
      wanted_in  = cur_wanted;
      limit_in   = cur_limit;
      for (int j = 0; j < WIN; j++) begin
         win_in[j] = cur_win[j];
      end
      pos_in      = cur_pos;
      count_in    = cur_count;
      seen_in     = cur_seen;
      phase_in    = cur_phase;
      counted     = 1'b0;
      emit        = 1'b0;
      emit_byte   = CH_NUL;
      emit_status = ST_CHAR;
      emit_last   = 1'b0;

      if (in_first_ff && (in_limit_ff == 16'd0)) begin
         phase_in    = PH_IDLE;
         emit        = 1'b1;
         emit_status = ST_MISS;
         emit_last   = 1'b1;
      end else begin
         unique case (cur_phase)
            PH_VALUE: begin
               emit = 1'b1;
               if ((in_byte_ff == CH_NUL) || is_line_end(in_byte_ff)) begin
                  phase_in    = PH_IDLE;
                  emit_status = ST_DONE;
                  emit_last   = 1'b1;
               end else begin
                  emit_byte = in_byte_ff;
               end
            end
            PH_SEARCH: begin
               for (int j = 0; j < WIN; j++) begin
                  win_in[j] = win_new[j];
               end
               if (here != POS_TOP) begin
                  pos_in = here + POSITION_BITS'(1);
               end
               if (in_byte_ff == CH_NUL) begin
                  phase_in    = PH_IDLE;
                  emit        = 1'b1;
                  emit_status = ST_MISS;
                  emit_last   = 1'b1;
               end else if (tag && (here >= POSITION_BITS'(cur_len))) begin
                  if ((here == POS_TOP) || (CMP_W'(start) >= CMP_W'(cur_limit))) begin
                     // Occurrence past the declared length ends the query.
                     phase_in    = PH_IDLE;
                     emit        = 1'b1;
                     emit_status = ST_MISS;
                     emit_last   = 1'b1;
                  end else begin
                     // History before the buffer start reads as NUL, so the
                     // line-start test needs no special case for position zero.
                     counted = !cur_seen || is_line_end(prev_byte);
                     seen_in = 1'b1;
                     if (counted) begin
                        if (cur_count == cur_wanted) begin
                           phase_in = PH_VALUE;
                        end else begin
                           count_in = cur_count + 10'd1;
                        end
                     end
                  end
               end
            end
            default: begin
               // Idle: bytes outside a query are dropped.
            end
         endcase
      end
   end

   // The registered request moves on unless it has a result and the result
   // register is still held by the receiver.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_ready || !emit);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   // Data registers; a new query always overwrites them before use.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff    <= req_data_byte;
         in_first_ff   <= req_first_byte;
         in_key_ff     <= key_padded;
         in_key_len_ff <= key_len_req;
         in_wanted_ff  <= req_wanted_index;
         in_limit_ff   <= req_buffer_length;
      end
      if (advance) begin
         for (int j = 0; j < WIN; j++) begin
            win_ff[j] <= win_in[j];
         end
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         seen_ff    <= seen_in;
         key_ff     <= key_in;
         key_len_ff <= key_len_in;
         wanted_ff  <= wanted_in;
         limit_ff   <= limit_in;
      end
      if (advance && emit) begin
         rsp_byte_ff   <= emit_byte;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_byte = rsp_byte_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### hw/rtl/lkve_checker.sv
// Port-level checker of the line key/value extractor and its bind to the top level.
module lkve_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_value_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import lkve_pkg::*;

   // Reset empties both the input and the result register.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty after reset");

   // A stalled result holds still.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_value_byte) && $stable(rsp_status) && $stable(rsp_last)))
      else $error("stalled result changed");

   // Characters never end a query; completion and not-found always do, with a zero byte.
   a_result_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_CHAR && !rsp_last) ||
                     ((rsp_status == ST_DONE || rsp_status == ST_MISS) &&
                      rsp_last && (rsp_value_byte == CH_NUL))))
      else $error("malformed result");

   // With no result waiting, requests are never held off.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

endmodule

bind line_key_value_extractor lkve_checker u_lkve_checker (.*);

### test/line_key_value_extractor_tb.sv
// Self-checking testbench of the line key/value extractor: directed and random queries.
module line_key_value_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkve_pkg::*;

   // One result of the block, in the order of its ports.
   typedef struct packed {
      logic [7:0] value_byte;
      logic [1:0] status;
      logic       last;
   } extract_result_type;

   typedef logic [7:0] byte_queue_type[$];

   localparam int          KEY_MAX      = 8;
   localparam int          WINDOW_LEN   = KEY_MAX + 2;
   localparam logic [15:0] POSITION_TOP = 16'hFFFF;
   localparam int          RANDOM_BYTES = 1000;
   localparam int          REPORT_LIMIT = 10;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte     = 8'h00;
   logic        req_first_byte    = 1'b0;
   logic [63:0] req_key_text      = 64'h0;
   logic [3:0]  req_key_length    = 4'h0;
   logic [9:0]  req_wanted_index  = 10'h0;
   logic [15:0] req_buffer_length = 16'h0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [7:0]  rsp_value_byte;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   line_key_value_extractor i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_first_byte    (req_first_byte),
      .req_key_text      (req_key_text),
      .req_key_length    (req_key_length),
      .req_wanted_index  (req_wanted_index),
      .req_buffer_length (req_buffer_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_byte    (rsp_value_byte),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // Our own copy of the search state. history[0] always holds the newest byte.
   logic [7:0]  history [WINDOW_LEN];
   logic [15:0] next_position;
   logic [9:0]  occurrences;
   logic        any_match_seen;
   phase_type   query_phase;
   logic [7:0]  query_key [KEY_MAX];
   int          query_key_len;
   logic [9:0]  query_wanted;
   logic [15:0] query_limit;

   // Results that the accepted requests must still produce, oldest first.
   extract_result_type awaited_results[$];
   int                 failure_count = 0;

   // When set, neither the sender nor the receiver idles between requests.
   bit free_run    = 1'b0;
   // A non-zero value asks the receiver for one long hold-off of that many cycles.
   int hold_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Works out what one accepted request must produce and queues it. The structure
   // follows the block: a first byte restarts everything, the value phase passes bytes
   // through, and the search phase slides the window and looks for the key tag.
   function automatic void predict_extraction(input logic [7:0] data, input logic first,
                                              input logic [63:0] key_text,
                                              input logic [3:0] key_length,
                                              input logic [9:0] wanted,
                                              input logic [15:0] limit);
      int          take;
      int          i;
      logic        stop;
      logic        hit;
      logic        counted;
      logic [15:0] here_pos;
      logic [15:0] start_pos;
      logic [7:0]  before_tag;
      if (first) begin
         // Overlong key lengths are clipped, and the key ends at its first zero byte.
         take = (key_length > KEY_MAX) ? KEY_MAX : key_length;
         stop = 1'b0;
         query_key_len = 0;
         for (i = 0; i < KEY_MAX; i++) query_key[i] = CH_NUL;
         for (i = 0; i < WINDOW_LEN; i++) history[i] = CH_NUL;
         for (i = 0; i < take; i++) begin
            if (key_text[8*i +: 8] == CH_NUL) stop = 1'b1;
            if (!stop) begin
               query_key[i]  = key_text[8*i +: 8];
               query_key_len = i + 1;
            end
         end
         query_wanted   = wanted;
         query_limit    = limit;
         next_position  = 16'h0;
         occurrences    = 10'h0;
         any_match_seen = 1'b0;
         query_phase    = PH_SEARCH;
         if (query_limit == 16'h0) begin
            // A zero declared length answers not-found at once.
            query_phase = PH_IDLE;
            awaited_results.push_back('{CH_NUL, ST_MISS, 1'b1});
            return;
         end
      end

      if (query_phase == PH_VALUE) begin
         if (data == CH_NUL || is_line_end(data)) begin
            query_phase = PH_IDLE;
            awaited_results.push_back('{CH_NUL, ST_DONE, 1'b1});
         end else begin
            awaited_results.push_back('{data, ST_CHAR, 1'b0});
         end
         return;
      end
      if (query_phase != PH_SEARCH) return;

      for (i = WINDOW_LEN - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = data;
      here_pos   = next_position;
      if (next_position != POSITION_TOP) next_position = next_position + 16'd1;

      if (data == CH_NUL) begin
         query_phase = PH_IDLE;
         awaited_results.push_back('{CH_NUL, ST_MISS, 1'b1});
         return;
      end

      // The tag ends on the newest byte with '='; the key sits just before it.
      hit = (history[0] == CH_EQUALS);
      for (i = 0; i < query_key_len; i++)
         if (history[query_key_len - i] != query_key[i]) hit = 1'b0;
      if (!hit || here_pos < query_key_len) return;

      start_pos = here_pos - query_key_len[15:0];
      if (here_pos == POSITION_TOP || start_pos >= query_limit) begin
         query_phase = PH_IDLE;
         awaited_results.push_back('{CH_NUL, ST_MISS, 1'b1});
         return;
      end

      // The first occurrence counts anywhere, later ones only at the start of a line.
      if (!any_match_seen) begin
         counted = 1'b1;
      end else begin
         before_tag = (start_pos > 16'h0) ? history[query_key_len + 1] : CH_NUL;
         counted    = is_line_end(before_tag);
      end
      any_match_seen = 1'b1;
      if (!counted) return;
      if (occurrences == query_wanted) query_phase = PH_VALUE;
      else occurrences = occurrences + 10'd1;
   endfunction

   task automatic note_failure(input string what, input extract_result_type want,
                               input extract_result_type got);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display({"%0t ns: %s: expected value %h status %0d last %0d, ",
                   "got value %h status %0d last %0d"},
                  $time, what, want.value_byte, want.status, want.last,
                  got.value_byte, got.status, got.last);
   endtask

   // Every result taken by the receiver is compared with the oldest awaited one.
   always @(posedge clock) begin
      extract_result_type got;
      extract_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_value_byte, rsp_status, rsp_last};
         if (awaited_results.size() == 0) begin
            note_failure("result with none awaited", '0, got);
         end else begin
            want = awaited_results.pop_front();
            if (got.value_byte !== want.value_byte || got.status !== want.status ||
                got.last !== want.last)
               note_failure("result mismatch", want, got);
         end
      end
   end

   // The receiver stalls a random number of cycles before each result, or takes one
   // long hold-off when the running test asks for it.
   initial begin
      int stall;
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            stall = free_run ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && hold_cycles == 0) @(posedge clock);
      end
   end

   // Offers one request after a random gap and holds it until the block takes it.
   task automatic send_request(input logic [7:0] data, input logic first,
                               input logic [63:0] key_text, input logic [3:0] key_length,
                               input logic [9:0] wanted, input logic [15:0] limit);
      int gap;
      gap = free_run ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_first_byte    <= first;
      req_key_text      <= key_text;
      req_key_length    <= key_length;
      req_wanted_index  <= wanted;
      req_buffer_length <= limit;
      do @(posedge clock); while (!req_ready);
      predict_extraction(data, first, key_text, key_length, wanted, limit);
   endtask

   // Sends a whole buffer. Only the first request carries the query; the others carry
   // random query fields, which the block must ignore.
   task automatic send_query(input byte_queue_type text, input logic [63:0] key_text,
                             input logic [3:0] key_length, input logic [9:0] wanted,
                             input logic [15:0] limit);
      int i;
      for (i = 0; i < text.size(); i++)
         if (i == 0) send_request(text[0], 1'b1, key_text, key_length, wanted, limit);
         else send_request(text[i], 1'b0, {$urandom, $urandom}, 4'($urandom),
                           10'($urandom), 16'($urandom));
   endtask

   // Stops offering requests and waits until every awaited result has come, then waits on
   // for anything the block might still wrongly produce.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Turns a string into buffer bytes: '^' stands for CR, '|' for LF and '~' for NUL.
   function automatic byte_queue_type line_text(input string s);
      byte_queue_type q;
      int             i;
      for (i = 0; i < s.len(); i++)
         case (s[i])
            "^":     q.push_back(CH_CR);
            "|":     q.push_back(CH_LF);
            "~":     q.push_back(CH_NUL);
            default: q.push_back(s[i]);
         endcase
      return q;
   endfunction

   // Packs a key with its first character in the lowest byte.
   function automatic logic [63:0] key_of(input string s);
      logic [63:0] packed_key;
      int          i;
      packed_key = 64'h0;
      for (i = 0; i < s.len() && i < 8; i++) packed_key[8*i +: 8] = s[i];
      return packed_key;
   endfunction

   // Bytes without a first byte while idle must produce nothing.
   task automatic test_idle_bytes();
      send_request(CH_NUL, 1'b0, {$urandom, $urandom}, 4'hF, 10'h3FF, 16'hFFFF);
      send_request(8'hFF, 1'b0, {$urandom, $urandom}, 4'h1, 10'h0, 16'h0);
      drain_results();
   endtask

   // A zero declared length answers not-found on the first byte; the rest is ignored.
   task automatic test_zero_length();
      send_query(line_text("k="), key_of("k"), 4'd1, 10'd0, 16'd0);
      drain_results();
   endtask

   // A NUL during the search ends the query, even with the highest index and length.
   task automatic test_nul_while_searching();
      send_query(line_text("k=~"), key_of("k"), 4'd1, 10'h3FF, 16'hFFFF);
      drain_results();
   endtask

   // The first occurrence counts anywhere; of the later ones, the one straight after
   // another tag is skipped and the one after CR is taken.
   task automatic test_line_start_rule();
      send_query(line_text("k=k=^k=Z|"), key_of("k"), 4'd1, 10'd1, 16'd40);
      drain_results();
   endtask

   // Clipped key length, a query abandoned mid-value, a bare '=' tag and a key cut
   // short by a zero byte, with the extreme value bytes.
   task automatic test_key_forms();
      send_query(line_text("abcdefgh=\200"), key_of("abcdefgh"), 4'd15, 10'd0, 16'd20);
      send_query(line_text("=\001^"), 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 10'd0, 16'd1);
      send_query(line_text("\377=\377~"), 64'h0000_0000_0000_00FF, 4'd9, 10'd0, 16'd3);
      drain_results();
   endtask

   // An occurrence starting at the declared length is not-found.
   task automatic test_past_length();
      send_query(line_text("xk="), key_of("k"), 4'd1, 10'd0, 16'd1);
      drain_results();
   endtask

   // The receiver holds off for a long time while a long value streams in, so the
   // block fills up and must stall its input.
   task automatic test_receiver_hold();
      free_run    = 1'b1;
      hold_cycles = 90;
      send_query(line_text("v=abcdefghijklmnopqrstuvwxyz0123|"), key_of("v"), 4'd1,
                 10'd0, 16'd64);
      free_run = 1'b0;
      drain_results();
   endtask

   // Many line-start occurrences in a row before the wanted one is reached.
   task automatic test_high_occurrence();
      byte_queue_type text;
      int             wanted;
      wanted   = $urandom_range(60, 120);
      text     = line_text("r=");
      repeat (wanted) text = {text, line_text("|r=")};
      text     = {text, line_text("ok|")};
      free_run = 1'b1;
      send_query(text, key_of("r"), 4'd1, 10'(wanted), 16'hFFFF);
      free_run = 1'b0;
      drain_results();
   endtask

   // Mostly well-formed buffers built from the key, line ends, values and filler, with
   // random bytes, cut-off queries and stray idle bytes mixed in.
   task automatic test_random_queries();
      byte_queue_type text;
      byte_queue_type key_chars;
      logic [63:0]    key_text;
      logic [3:0]     key_length;
      logic [9:0]     wanted;
      logic [15:0]    limit;
      int             sent;
      int             cut;
      int             take;
      int             span;
      int             i;
      logic           stop;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         free_run = ($urandom_range(0, 7) == 0);

         case ($urandom_range(0, 15))
            12:      key_length = 4'd0;
            13, 14:  key_length = 4'($urandom_range(9, 15));
            15:      key_length = 4'd8;
            default: key_length = 4'($urandom_range(1, 8));
         endcase
         key_text = {$urandom, $urandom};
         take     = (key_length > KEY_MAX) ? KEY_MAX : key_length;
         for (i = 0; i < take; i++)
            if ($urandom_range(0, 15) != 0) key_text[8*i +: 8] = 8'("a" + $urandom_range(0, 3));
         if (take > 0 && $urandom_range(0, 11) == 0)
            key_text[8*$urandom_range(0, take - 1) +: 8] = CH_NUL;
         key_chars = {};
         stop      = 1'b0;
         for (i = 0; i < take; i++) begin
            if (key_text[8*i +: 8] == CH_NUL) stop = 1'b1;
            if (!stop) key_chars.push_back(key_text[8*i +: 8]);
         end

         text = {};
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 6))
               0: text.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
               1, 2, 3: begin
                  if (text.size() > 0 && $urandom_range(0, 3) != 0)
                     text.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                  text = {text, key_chars};
                  text.push_back(CH_EQUALS);
                  repeat ($urandom_range(0, 4))
                     text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                                : 8'("a" + $urandom_range(0, 25)));
                  text.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
               end
               4: repeat ($urandom_range(1, 4))
                     text.push_back(($urandom_range(0, 4) == 0) ? CH_EQUALS
                                                                : 8'("a" + $urandom_range(0, 3)));
               5: text.push_back(8'($urandom));
               default: begin
                  // A partial key, which must not be mistaken for a tag.
                  span = (key_chars.size() > 0) ? $urandom_range(0, key_chars.size() - 1) : 0;
                  for (i = 0; i < span; i++) text.push_back(key_chars[i]);
               end
            endcase
         end
         text.push_back(CH_NUL);

         case ($urandom_range(0, 9))
            0:       limit = 16'd0;
            1:       limit = 16'($urandom);
            default: begin
               span  = text.size() + $urandom_range(0, 6) - 3;
               limit = (span < 0) ? 16'd0 : 16'(span);
            end
         endcase
         case ($urandom_range(0, 9))
            7, 8:    wanted = 10'($urandom_range(3, 6));
            9:       wanted = 10'($urandom_range(0, 1023));
            default: wanted = 10'($urandom_range(0, 2));
         endcase

         // Now and then the buffer is cut off and the next query starts mid-way.
         cut = text.size();
         if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, text.size());
         while (text.size() > cut) void'(text.pop_back());
         for (i = 0; i < text.size(); i++) begin
            sent++;
            if (i == 0) send_request(text[0], 1'b1, key_text, key_length, wanted, limit);
            else send_request(text[i], 1'b0, {$urandom, $urandom}, 4'($urandom),
                              10'($urandom), 16'($urandom));
         end

         // Stray bytes between queries are ignored by an idle block.
         if (query_phase == PH_IDLE && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) begin
               sent++;
               send_request(8'($urandom), 1'b0, {$urandom, $urandom}, 4'($urandom),
                            10'($urandom), 16'($urandom));
            end
      end
      free_run = 1'b0;
      drain_results();
   endtask

   initial begin
      int i;
      for (i = 0; i < WINDOW_LEN; i++) history[i] = CH_NUL;
      for (i = 0; i < KEY_MAX; i++) query_key[i] = CH_NUL;
      next_position  = 16'h0;
      occurrences    = 10'h0;
      any_match_seen = 1'b0;
      query_phase    = PH_IDLE;
      query_key_len  = 0;
      query_wanted   = 10'h0;
      query_limit    = 16'h0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_bytes();
      test_zero_length();
      test_nul_while_searching();
      test_line_start_rule();
      test_key_forms();
      test_past_length();
      test_receiver_hold();
      test_high_occurrence();
      test_random_queries();

      if (failure_count == 0 && awaited_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Safety net well beyond the slowest correct run.
   initial begin
      #1000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
